FILE: design/nsc_pkg.sv
// Package for the NMEA sentence checker: character codes, verdict codes and
// the result beat type shared by the parser, the output queue and the top level.
// No dependencies.
`default_nettype none

package nsc_pkg;

   // Characters that steer the parser
   localparam logic [7:0] CharDollar = 8'h24;
   localparam logic [7:0] CharComma  = 8'h2C;
   localparam logic [7:0] CharStar   = 8'h2A;
   localparam logic [7:0] CharCr     = 8'h0D;
   localparam logic [7:0] CharLf     = 8'h0A;

   // Sentences with fewer tokens than this are rejected
   localparam int unsigned MinTokens = 3;
   // Characters kept of the sentence type
   localparam int unsigned TypeChars = 6;

   typedef enum logic [1:0] {
      STATUS_VALID    = 2'd0,
      STATUS_MISMATCH = 2'd1,
      STATUS_TOO_FEW  = 2'd2
   } status_type;

   // One verdict beat
   typedef struct packed {
      status_type  status;
      logic        checksum_present;
      logic [5:0]  data_field_count;
      logic [47:0] sentence_type;
      logic [7:0]  computed_checksum;
      logic [7:0]  received_checksum;
   } result_type;

endpackage

`default_nettype wire

FILE: design/nsc_parser.sv
// Input register and per-byte sentence parser of the NMEA sentence checker.
// Depends on nsc_pkg; hands finished verdicts to nsc_out_queue.
`default_nettype none

module nsc_parser
   import nsc_pkg::*;
#(
   parameter int unsigned MAX_TOKENS = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        queue_full,
   output logic             emit,
   output result_type       result
);

   localparam int unsigned CW = $clog2(MAX_TOKENS + 1);
   localparam int unsigned EW = CW + 6;

   // Returns {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] byte_ff;

   // Sentence state
   logic          in_sentence_ff, in_sentence_in;
   logic          star_seen_ff, star_seen_in;
   logic [7:0]    running_xor_ff, running_xor_in;
   logic [7:0]    hex_value_ff, hex_value_in;
   logic          hex_stopped_ff, hex_stopped_in;
   logic          hex_digits_ff, hex_digits_in;
   logic          token_open_ff, token_open_in;
   logic [CW-1:0] token_count_ff, token_count_in;
   logic [CW-1:0] data_tokens_ff, data_tokens_in;
   logic [47:0]   type_chars_ff, type_chars_in;
   logic [2:0]    type_length_ff, type_length_in;

   logic          advance;
   logic          ends_sentence;
   logic [4:0]    hex;
   logic [CW-1:0] dt;
   logic [EW-1:0] dt_ext;
   logic [EW-1:0] data_m1;

   // A terminator needs room in the queue; every other byte moves on at once
   assign ends_sentence = in_sentence_ff && byte_ff != CharDollar &&
                          (byte_ff == CharCr || byte_ff == CharLf);
   assign advance   = in_valid_ff && (!ends_sentence || !queue_full);
   assign req_ready = !in_valid_ff || advance;
   assign hex       = hex_decode(byte_ff);

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   // Verdict for the sentence held in the state registers
   always_comb begin
      dt_ext  = EW'(data_tokens_ff);
      data_m1 = (dt_ext == '0) ? '0 : dt_ext - EW'(1);
      result.data_field_count  = (data_m1 > EW'(63)) ? 6'd63 : data_m1[5:0];
      result.checksum_present  = star_seen_ff && hex_digits_ff;
      result.sentence_type     = type_chars_ff;
      result.computed_checksum = running_xor_ff;
      result.received_checksum = hex_value_ff;
      if (token_count_ff < CW'(MinTokens)) begin
         result.status = STATUS_TOO_FEW;
      end else if (star_seen_ff && running_xor_ff != hex_value_ff) begin
         result.status = STATUS_MISMATCH;
      end else begin
         result.status = STATUS_VALID;
      end
   end

   // Next sentence state for the byte in the input register
   always_comb begin
      in_sentence_in = in_sentence_ff;
      star_seen_in   = star_seen_ff;
      running_xor_in = running_xor_ff;
      hex_value_in   = hex_value_ff;
      hex_stopped_in = hex_stopped_ff;
      hex_digits_in  = hex_digits_ff;
      token_open_in  = token_open_ff;
      token_count_in = token_count_ff;
      data_tokens_in = data_tokens_ff;
      type_chars_in  = type_chars_ff;
      type_length_in = type_length_ff;
      dt             = data_tokens_ff;
      emit           = 1'b0;

      if (advance) begin
         if (byte_ff == CharDollar || ends_sentence) begin
            // Start, restart or end of a sentence: clear everything
            emit           = ends_sentence;
            in_sentence_in = !ends_sentence;
            star_seen_in   = 1'b0;
            running_xor_in = '0;
            hex_value_in   = '0;
            hex_stopped_in = 1'b0;
            hex_digits_in  = 1'b0;
            token_open_in  = 1'b0;
            token_count_in = '0;
            data_tokens_in = '0;
            type_chars_in  = '0;
            type_length_in = '0;
         end else if (in_sentence_ff) begin
            if (!star_seen_ff && byte_ff == CharStar) begin
               // First star closes the checksummed part
               star_seen_in  = 1'b1;
               token_open_in = 1'b0;
            end else begin
               // Checksum accumulation or hex collection
               if (!star_seen_ff) begin
                  running_xor_in = running_xor_ff ^ byte_ff;
               end else if (!hex_stopped_ff) begin
                  if (hex[4]) begin
                     hex_value_in  = {hex_value_ff[3:0], hex[3:0]};
                     hex_digits_in = 1'b1;
                  end else begin
                     hex_stopped_in = 1'b1;
                  end
               end
               // Token tracking and type capture
               if (byte_ff == CharComma || byte_ff == CharStar) begin
                  token_open_in = 1'b0;
               end else begin
                  if (!token_open_ff) begin
                     token_open_in = 1'b1;
                     if (token_count_ff < CW'(MAX_TOKENS)) begin
                        token_count_in = token_count_ff + CW'(1);
                     end
                     if (!star_seen_ff && data_tokens_ff < CW'(MAX_TOKENS)) begin
                        dt = data_tokens_ff + CW'(1);
                     end
                  end
                  data_tokens_in = dt;
                  if (!star_seen_ff && dt == CW'(1) && type_length_ff < 3'(TypeChars)) begin
                     for (int i = 0; i < 6; i++) begin
                        if (type_length_ff == 3'(5 - i)) begin
                           type_chars_in[8*i +: 8] = byte_ff;
                        end
                     end
                     type_length_in = type_length_ff + 3'd1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         star_seen_ff   <= 1'b0;
         running_xor_ff <= '0;
         hex_value_ff   <= '0;
         hex_stopped_ff <= 1'b0;
         hex_digits_ff  <= 1'b0;
         token_open_ff  <= 1'b0;
         token_count_ff <= '0;
         data_tokens_ff <= '0;
         type_chars_ff  <= '0;
         type_length_ff <= '0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         star_seen_ff   <= star_seen_in;
         running_xor_ff <= running_xor_in;
         hex_value_ff   <= hex_value_in;
         hex_stopped_ff <= hex_stopped_in;
         hex_digits_ff  <= hex_digits_in;
         token_open_ff  <= token_open_in;
         token_count_ff <= token_count_in;
         data_tokens_ff <= data_tokens_in;
         type_chars_ff  <= type_chars_in;
         type_length_ff <= type_length_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/nsc_out_queue.sv
// Two-entry result queue of the NMEA sentence checker; drives the rsp_ channel.
// Depends on nsc_pkg for the result beat type.
`default_nettype none

module nsc_out_queue
   import nsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire result_type  wr_data,
   output logic             full,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rd_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign full      = count_ff == 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rd_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(wr_en) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/nmea_sentence_checker_core.sv
// Top level of the NMEA sentence checker: parser with input register feeding a
// two-entry result queue. Depends on nsc_pkg, nsc_parser and nsc_out_queue.
//
//   channel | direction | handshake           | payload
//   req_    | in        | req_valid/req_ready | req_rx_byte
//   rsp_    | out       | rsp_valid/rsp_ready | status, checksum_present, counts, type, sums
//
// One byte beat is accepted per cycle while req_ready is high; a byte is parsed from the
// input register, and a CR or LF that ends a sentence then writes its verdict to the queue.
// The result queue holds two verdicts; only a terminator byte that ends a sentence waits
// for queue room, so req_ready falls only while the queue is full and such a terminator
// sits in the input register. Reset is synchronous and clears the sentence state and queue.
`default_nettype none

module nmea_sentence_checker_core
   import nsc_pkg::*;
#(
   parameter int unsigned MAX_TOKENS = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic             rsp_checksum_present,
   output logic [5:0]       rsp_data_field_count,
   output logic [47:0]      rsp_sentence_type,
   output logic [7:0]       rsp_computed_checksum,
   output logic [7:0]       rsp_received_checksum
);

   logic       queue_full;
   logic       emit;
   result_type result;
   result_type head;

   nsc_parser #(
      .MAX_TOKENS (MAX_TOKENS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (queue_full),
      .emit        (emit),
      .result      (result)
   );

   nsc_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (emit),
      .wr_data   (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rd_data   (head)
   );

   // Result fields
   assign rsp_status            = head.status;
   assign rsp_checksum_present  = head.checksum_present;
   assign rsp_data_field_count  = head.data_field_count;
   assign rsp_sentence_type     = head.sentence_type;
   assign rsp_computed_checksum = head.computed_checksum;
   assign rsp_received_checksum = head.received_checksum;

endmodule

`default_nettype wire
